// ===== rtl/core/tvmc_pkg.sv =====
// Shared types, constants and fixed-point helpers for the three-view point fit.
`default_nettype none

package tvmc_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int SIG_W   = 16;
    localparam int TRIG_W  = 18;
    localparam int CHI_W   = 32;

    // Configuration register file
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIN_U   = 3'd0,
        CFG_COS_U   = 3'd1,
        CFG_SIN_V   = 3'd2,
        CFG_COS_V   = 3'd3,
        CFG_SIN_UPV = 3'd4
    } t_cfg_idx;

    typedef logic signed [TRIG_W-1:0]  t_trig;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [SIG_W-1:0]   t_sig;

    localparam t_trig TRIG_ONE      = 18'sd65536;
    localparam t_trig RST_SIN_U     = 18'sd56756;
    localparam t_trig RST_COS_U     = 18'sd32768;
    localparam t_trig RST_SIN_V     = 18'sd56756;
    localparam t_trig RST_COS_V     = 18'sd32768;
    localparam t_trig RST_SIN_UPV   = 18'sd56756;

    // Divider geometry: y/z solve and residual scaling
    localparam int YZ_NUM_W  = 62;
    localparam int YZ_DEN_W  = 31;
    localparam int YZ_Q_W    = 32;
    localparam int CHI_NUM_W = 49;
    localparam int CHI_DEN_W = 22;
    localparam int CHI_Q_W   = 24;

    // Accept-to-strobe path: five front stages, y/z divider, three
    // residual stages, residual divider, square and sum stages
    localparam int PIPE_LAT = 5 + (YZ_Q_W + 1) + 3 + (CHI_Q_W + 1) + 2;

    // One hit as it travels down the pipe
    typedef struct packed {
        t_coord coord_u;
        t_coord coord_v;
        t_coord coord_w;
        t_sig   sig_u;
        t_sig   sig_v;
        t_sig   sig_w;
        logic   err;
    } t_hit;

    localparam int HIT_W = $bits(t_hit);

    // Shift right by s, rounding half away from zero
    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] x,
                                                  input int unsigned s);
        logic [63:0] mag;
        mag = x[63] ? 64'(-x) : 64'(x);
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return x[63] ? -$signed(mag) : $signed(mag);
    endfunction

    // Clamp a trig register to +-1.0
    function automatic t_trig sat_trig(input t_trig t);
        if (t > TRIG_ONE) begin
            return TRIG_ONE;
        end else if (t < -TRIG_ONE) begin
            return -TRIG_ONE;
        end
        return t;
    endfunction

    // Product of two trig values, rounded back to Q16
    function automatic t_trig trig_mul(input t_trig a, input t_trig b);
        logic signed [35:0] p;
        p = 36'(a) * 36'(b);
        return 18'(rnd_sh(64'(p), 16));
    endfunction

    // a*b + c*d of trig values, rounded back to Q16
    function automatic logic signed [18:0] trig_mac(input t_trig a, input t_trig b,
                                                    input t_trig c, input t_trig d);
        logic signed [36:0] p;
        p = 37'(a) * 37'(b) + 37'(c) * 37'(d);
        return 19'(rnd_sh(64'(p), 16));
    endfunction

    // Sigma (Q8) times a Q16 trig term
    function automatic logic signed [34:0] sig_mul(input t_sig sg, input t_trig t);
        return 35'($signed({1'b0, sg})) * 35'(t);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/three_view_min_chi2_point_top.sv =====
// Top level of the three-view minimum chi-squared point fit pipeline.
//
//  channel   direction  handshake                     word
//  command   in         i_start && !o_busy            coord_u/v/w, weight_u/v/w
//  result    out        o_done (one-cycle strobe)     pos_y, pos_z, chi_sq, fit_error
//  config    in         i_cfg_valid && o_cfg_ready    i_cfg_idx, i_cfg_data
//
// One hit is taken every cycle. Each command passes through the two
// bit-serial divider pipelines: 33 stages for the y/z solve and 25 for the
// residual scaling, plus 10 stages of multiply, round and sum. o_busy stays
// low: nothing downstream can stall.
// Reset clears the valid bits and loads the trig registers with their defaults.
`default_nettype none

module three_view_min_chi2_point_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [tvmc_pkg::COORD_W-1:0] i_coord_u,
    input  logic signed [tvmc_pkg::COORD_W-1:0] i_coord_v,
    input  logic signed [tvmc_pkg::COORD_W-1:0] i_coord_w,
    input  logic        [tvmc_pkg::SIG_W-1:0]   i_weight_u,
    input  logic        [tvmc_pkg::SIG_W-1:0]   i_weight_v,
    input  logic        [tvmc_pkg::SIG_W-1:0]   i_weight_w,
    output logic                                o_done,
    output logic signed [tvmc_pkg::COORD_W-1:0] o_pos_y,
    output logic signed [tvmc_pkg::COORD_W-1:0] o_pos_z,
    output logic        [tvmc_pkg::CHI_W-1:0]   o_chi_sq,
    output logic                                o_fit_error,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [tvmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic signed [tvmc_pkg::TRIG_W-1:0]  i_cfg_data
);

    import tvmc_pkg::*;

    localparam int YZ_SIDE_W  = HIT_W + 2;
    localparam int CHI_SIDE_W = 2 * COORD_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_trig r_sin_u, r_cos_u, r_sin_v, r_cos_v, r_sin_upv;
    t_trig su, cu, sv, cv, sp;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    // Write one register; drop indexes beyond the file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_u   <= RST_SIN_U;
            r_cos_u   <= RST_COS_U;
            r_sin_v   <= RST_SIN_V;
            r_cos_v   <= RST_COS_V;
            r_sin_upv <= RST_SIN_UPV;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SIN_U:   r_sin_u   <= i_cfg_data;
                CFG_COS_U:   r_cos_u   <= i_cfg_data;
                CFG_SIN_V:   r_sin_v   <= i_cfg_data;
                CFG_COS_V:   r_cos_v   <= i_cfg_data;
                CFG_SIN_UPV: r_sin_upv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign su = sat_trig(r_sin_u);
    assign cu = sat_trig(r_cos_u);
    assign sv = sat_trig(r_sin_v);
    assign cv = sat_trig(r_cos_v);
    assign sp = sat_trig(r_sin_upv);

    // ------------------------------------------------------------------
    // Stage 1: capture the hit, form trig products
    // ------------------------------------------------------------------
    logic              r1_vld;
    t_hit              r1_hit;
    t_trig             r1_su2, r1_sv2, r1_cvsv, r1_cusu, r1_cvsp, r1_cusp, r1_svsp, r1_susp;
    logic signed [18:0] r1_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_hit.coord_u <= i_coord_u;
        r1_hit.coord_v <= i_coord_v;
        r1_hit.coord_w <= i_coord_w;
        r1_hit.sig_u   <= i_weight_u;
        r1_hit.sig_v   <= i_weight_v;
        r1_hit.sig_w   <= i_weight_w;
        r1_hit.err     <= (i_weight_u == '0) || (i_weight_v == '0) || (i_weight_w == '0);
        r1_su2  <= trig_mul(su, su);
        r1_sv2  <= trig_mul(sv, sv);
        r1_cvsv <= trig_mul(cv, sv);
        r1_cusu <= trig_mul(cu, su);
        r1_cvsp <= trig_mul(cv, sp);
        r1_cusp <= trig_mul(cu, sp);
        r1_svsp <= trig_mul(sv, sp);
        r1_susp <= trig_mul(su, sp);
        r1_a    <= trig_mac(cv, su, cu, sv);
    end

    // ------------------------------------------------------------------
    // Stage 2: square the cross term, scale trig terms by sigma
    // ------------------------------------------------------------------
    logic               r2_vld;
    t_hit               r2_hit;
    logic signed [19:0] r2_a2;
    logic signed [34:0] r2_p_vsu, r2_p_wcvsp, r2_p_usv, r2_p_wcusp, r2_p_vcusu;
    logic signed [34:0] r2_p_ucvsv, r2_p_wsvsp, r2_p_wsusp, r2_p_usv2, r2_p_vsu2;
    logic signed [37:0] a_sq;

    assign a_sq = 38'(r1_a) * 38'(r1_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_hit     <= r1_hit;
        r2_a2      <= 20'(rnd_sh(64'(a_sq), 16));
        r2_p_vsu   <= sig_mul(r1_hit.sig_v, su);
        r2_p_wcvsp <= sig_mul(r1_hit.sig_w, r1_cvsp);
        r2_p_usv   <= sig_mul(r1_hit.sig_u, sv);
        r2_p_wcusp <= sig_mul(r1_hit.sig_w, r1_cusp);
        r2_p_vcusu <= sig_mul(r1_hit.sig_v, r1_cusu);
        r2_p_ucvsv <= sig_mul(r1_hit.sig_u, r1_cvsv);
        r2_p_wsvsp <= sig_mul(r1_hit.sig_w, r1_svsp);
        r2_p_wsusp <= sig_mul(r1_hit.sig_w, r1_susp);
        r2_p_usv2  <= sig_mul(r1_hit.sig_u, r1_sv2);
        r2_p_vsu2  <= sig_mul(r1_hit.sig_v, r1_su2);
    end

    // ------------------------------------------------------------------
    // Stage 3: round the coefficients to Q20, start the denominator
    // ------------------------------------------------------------------
    logic               r3_vld;
    t_hit               r3_hit;
    logic signed [30:0] r3_kyu, r3_kyv, r3_kyw, r3_kzu, r3_kzv, r3_kzw;
    logic signed [35:0] r3_psum;
    logic signed [36:0] r3_p_wa2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_hit   <= r2_hit;
        r3_kyu   <= 31'(rnd_sh(-(64'(r2_p_vsu) + 64'(r2_p_wcvsp)), 4));
        r3_kyv   <= 31'(rnd_sh(64'(r2_p_usv) + 64'(r2_p_wcusp), 4));
        r3_kyw   <= 31'(rnd_sh(64'(r2_p_vcusu) - 64'(r2_p_ucvsv), 4));
        r3_kzu   <= 31'(rnd_sh(64'(r2_p_wsvsp), 4));
        r3_kzv   <= 31'(rnd_sh(64'(r2_p_wsusp), 4));
        r3_kzw   <= 31'(rnd_sh(64'(r2_p_usv2) + 64'(r2_p_vsu2), 4));
        r3_psum  <= 36'(r2_p_usv2) + 36'(r2_p_vsu2);
        r3_p_wa2 <= 37'($signed({1'b0, r2_hit.sig_w})) * 37'(r2_a2);
    end

    // ------------------------------------------------------------------
    // Stage 4: finish the denominator, multiply coefficients by coordinates
    // ------------------------------------------------------------------
    logic               r4_vld;
    t_hit               r4_hit;
    logic signed [31:0] r4_den;
    logic signed [62:0] r4_pyu, r4_pyv, r4_pyw, r4_pzu, r4_pzv, r4_pzw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_hit <= r3_hit;
        r4_den <= 32'(rnd_sh(64'(r3_psum) + 64'(r3_p_wa2), 4));
        r4_pyu <= 63'(r3_kyu) * 63'(r3_hit.coord_u);
        r4_pyv <= 63'(r3_kyv) * 63'(r3_hit.coord_v);
        r4_pyw <= 63'(r3_kyw) * 63'(r3_hit.coord_w);
        r4_pzu <= 63'(r3_kzu) * 63'(r3_hit.coord_u);
        r4_pzv <= 63'(r3_kzv) * 63'(r3_hit.coord_v);
        r4_pzw <= 63'(r3_kzw) * 63'(r3_hit.coord_w);
    end

    // ------------------------------------------------------------------
    // Stage 5: sum numerators, split sign and magnitude
    // ------------------------------------------------------------------
    logic                  r5_vld;
    t_hit                  r5_hit;
    logic [YZ_DEN_W-1:0]   r5_den;
    logic [YZ_NUM_W-1:0]   r5_y_mag, r5_z_mag;
    logic                  r5_y_neg, r5_z_neg;
    logic signed [63:0]    num_y, num_z;

    assign num_y = 64'(r4_pyu) + 64'(r4_pyv) + 64'(r4_pyw);
    assign num_z = 64'(r4_pzu) + 64'(r4_pzv) + 64'(r4_pzw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_hit.coord_u <= r4_hit.coord_u;
        r5_hit.coord_v <= r4_hit.coord_v;
        r5_hit.coord_w <= r4_hit.coord_w;
        r5_hit.sig_u   <= r4_hit.sig_u;
        r5_hit.sig_v   <= r4_hit.sig_v;
        r5_hit.sig_w   <= r4_hit.sig_w;
        r5_hit.err     <= r4_hit.err || (r4_den == '0);
        r5_den     <= r4_den[YZ_DEN_W-1:0];
        r5_y_neg   <= num_y[63];
        r5_z_neg   <= num_z[63];
        r5_y_mag   <= num_y[63] ? YZ_NUM_W'(-num_y) : YZ_NUM_W'(num_y);
        r5_z_mag   <= num_z[63] ? YZ_NUM_W'(-num_z) : YZ_NUM_W'(num_z);
    end

    // ------------------------------------------------------------------
    // y and z division
    // ------------------------------------------------------------------
    logic                          yz_vld;
    logic [1:0][YZ_Q_W-1:0]        yz_quo;
    logic [1:0]                    yz_ovf;
    logic [YZ_SIDE_W-1:0]          yz_side;

    tvmc_div #(
        .NUM_W  (YZ_NUM_W),
        .DEN_W  (YZ_DEN_W),
        .Q_W    (YZ_Q_W),
        .LANES  (2),
        .SIDE_W (YZ_SIDE_W)
    ) u_div_yz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_num   ({r5_z_mag, r5_y_mag}),
        .i_den   ({r5_den, r5_den}),
        .i_side  ({r5_y_neg, r5_z_neg, r5_hit}),
        .o_vld   (yz_vld),
        .o_quo   (yz_quo),
        .o_ovf   (yz_ovf),
        .o_side  (yz_side)
    );

    // ------------------------------------------------------------------
    // Stage 6: apply sign and saturate y, z
    // ------------------------------------------------------------------
    logic   r6_vld;
    t_hit   r6_hit;
    t_coord r6_y, r6_z;
    logic   yz_y_neg, yz_z_neg;
    t_hit   yz_hit;

    assign yz_y_neg = yz_side[YZ_SIDE_W-1];
    assign yz_z_neg = yz_side[YZ_SIDE_W-2];
    assign yz_hit   = t_hit'(yz_side[HIT_W-1:0]);

    function automatic t_coord sat_quo(input logic neg, input logic ovf,
                                       input logic [YZ_Q_W-1:0] q);
        if (!neg) begin
            return (ovf || q[YZ_Q_W-1]) ? t_coord'({1'b0, {(COORD_W-1){1'b1}}}) : t_coord'(q);
        end
        if (ovf || (q[YZ_Q_W-1] && (q[YZ_Q_W-2:0] != '0))) begin
            return t_coord'({1'b1, {(COORD_W-1){1'b0}}});
        end
        return t_coord'(-q);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= yz_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_hit <= yz_hit;
        r6_y   <= sat_quo(yz_y_neg, yz_ovf[0], yz_quo[0]);
        r6_z   <= sat_quo(yz_z_neg, yz_ovf[1], yz_quo[1]);
    end

    // ------------------------------------------------------------------
    // Stage 7: project y, z back onto the planes
    // ------------------------------------------------------------------
    logic               r7_vld;
    t_hit               r7_hit;
    t_coord             r7_y, r7_z;
    logic signed [49:0] r7_zcu, r7_ysu, r7_zcv, r7_ysv;
    logic signed [32:0] r7_dw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_hit <= r6_hit;
        r7_y   <= r6_y;
        r7_z   <= r6_z;
        r7_zcu <= 50'(r6_z) * 50'(cu);
        r7_ysu <= 50'(r6_y) * 50'(su);
        r7_zcv <= 50'(r6_z) * 50'(cv);
        r7_ysv <= 50'(r6_y) * 50'(sv);
        r7_dw  <= 33'(r6_hit.coord_w) - 33'(r6_z);
    end

    // ------------------------------------------------------------------
    // Stage 8: residual magnitudes and sigma divisors
    // ------------------------------------------------------------------
    logic                         r8_vld;
    logic [2:0][CHI_NUM_W-1:0]    r8_mag;
    logic [2:0][CHI_DEN_W-1:0]    r8_div;
    logic [CHI_SIDE_W-1:0]        r8_side;
    logic signed [51:0]           res_u, res_v, res_w;

    assign res_u = $signed({{4{r7_hit.coord_u[COORD_W-1]}}, r7_hit.coord_u, 16'h0000})
                 - 52'(r7_zcu) + 52'(r7_ysu);
    assign res_v = $signed({{4{r7_hit.coord_v[COORD_W-1]}}, r7_hit.coord_v, 16'h0000})
                 - 52'(r7_zcv) - 52'(r7_ysv);
    assign res_w = $signed({{3{r7_dw[32]}}, r7_dw, 16'h0000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_mag[0] <= res_u[51] ? CHI_NUM_W'(-res_u) : CHI_NUM_W'(res_u);
        r8_mag[1] <= res_v[51] ? CHI_NUM_W'(-res_v) : CHI_NUM_W'(res_v);
        r8_mag[2] <= res_w[51] ? CHI_NUM_W'(-res_w) : CHI_NUM_W'(res_w);
        r8_div[0] <= {r7_hit.sig_u, 6'b000000};
        r8_div[1] <= {r7_hit.sig_v, 6'b000000};
        r8_div[2] <= {r7_hit.sig_w, 6'b000000};
        r8_side   <= {r7_hit.err, r7_y, r7_z};
    end

    // ------------------------------------------------------------------
    // Residual scaling by sigma
    // ------------------------------------------------------------------
    logic                       chi_vld;
    logic [2:0][CHI_Q_W-1:0]    chi_quo;
    logic [2:0]                 chi_ovf;
    logic [CHI_SIDE_W-1:0]      chi_side;

    tvmc_div #(
        .NUM_W  (CHI_NUM_W),
        .DEN_W  (CHI_DEN_W),
        .Q_W    (CHI_Q_W),
        .LANES  (3),
        .SIDE_W (CHI_SIDE_W)
    ) u_div_chi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r8_vld),
        .i_num   (r8_mag),
        .i_den   (r8_div),
        .i_side  (r8_side),
        .o_vld   (chi_vld),
        .o_quo   (chi_quo),
        .o_ovf   (chi_ovf),
        .o_side  (chi_side)
    );

    // ------------------------------------------------------------------
    // Stage 9: square each scaled residual
    // ------------------------------------------------------------------
    logic                     r9_vld;
    logic [2:0][CHI_W-1:0]    r9_term;
    logic [CHI_SIDE_W-1:0]    r9_side;
    logic [2:0][47:0]         sq;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            sq[l] = 48'(chi_quo[l]) * 48'(chi_quo[l]) + 48'h8000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= chi_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r9_term[l] <= chi_ovf[l] ? {CHI_W{1'b1}} : sq[l][47:16];
        end
        r9_side <= chi_side;
    end

    // ------------------------------------------------------------------
    // Stage 10: saturating sum, zero the word on error, strobe out
    // ------------------------------------------------------------------
    logic               r_done;
    t_coord             r_pos_y, r_pos_z;
    logic [CHI_W-1:0]   r_chi_sq;
    logic               r_fit_error;
    logic [CHI_W+1:0]   chi_sum;
    logic               r9_err;

    assign chi_sum = (CHI_W+2)'(r9_term[0]) + (CHI_W+2)'(r9_term[1])
                   + (CHI_W+2)'(r9_term[2]);
    assign r9_err  = r9_side[CHI_SIDE_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fit_error <= r9_err;
        if (r9_err) begin
            r_pos_y  <= '0;
            r_pos_z  <= '0;
            r_chi_sq <= '0;
        end else begin
            r_pos_y  <= r9_side[2*COORD_W-1:COORD_W];
            r_pos_z  <= r9_side[COORD_W-1:0];
            r_chi_sq <= (chi_sum[CHI_W+1:CHI_W] != 2'b00) ? {CHI_W{1'b1}}
                                                           : chi_sum[CHI_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_pos_y     = r_pos_y;
    assign o_pos_z     = r_pos_z;
    assign o_chi_sq    = r_chi_sq;
    assign o_fit_error = r_fit_error;

`ifndef SYNTHESIS
    // Every accepted word comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##PIPE_LAT o_done)
        else $error("result strobe missing after accepted word");

    // No strobe without a matching accept
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, PIPE_LAT))
        else $error("result strobe without accepted word");

    // A zero sigma always ends in an error result
    a_zero_sigma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy &&
         (i_weight_u == '0 || i_weight_v == '0 || i_weight_w == '0))
        |-> ##PIPE_LAT o_fit_error)
        else $error("zero sigma did not flag an error");

    // Error results carry zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_fit_error) |-> (o_pos_y == '0 && o_pos_z == '0 && o_chi_sq == '0))
        else $error("error result with nonzero payload");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tvmc_div.sv =====
// Pipelined restoring divider: rounded quotient, one bit per stage, several lanes.
`default_nettype none

module tvmc_div #(
    parameter int NUM_W  = 62,
    parameter int DEN_W  = 31,
    parameter int Q_W    = 32,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic [LANES-1:0][NUM_W-1:0]       i_num,
    input  logic [LANES-1:0][DEN_W-1:0]       i_den,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_vld,
    output logic [LANES-1:0][Q_W-1:0]         o_quo,
    output logic [LANES-1:0]                  o_ovf,
    output logic [SIDE_W-1:0]                 o_side
);

    localparam int RW = (NUM_W + 1 > DEN_W + Q_W) ? NUM_W + 1 : DEN_W + Q_W;

    logic [LANES-1:0][RW-1:0]    r_rem  [Q_W];
    logic [LANES-1:0][DEN_W-1:0] r_den  [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_quo  [Q_W+1];
    logic [LANES-1:0]            r_ovf  [Q_W+1];
    logic [SIDE_W-1:0]           r_side [Q_W+1];
    logic                        r_vld  [Q_W+1];

    logic [LANES-1:0][RW-1:0]    n_rem0;
    logic [LANES-1:0]            n_ovf0;

    // Add half the divisor for rounding; flag quotients that do not fit
    always_comb begin
        logic [NUM_W:0] nr;
        for (int l = 0; l < LANES; l++) begin
            nr        = {1'b0, i_num[l]} + (NUM_W+1)'(i_den[l] >> 1);
            n_rem0[l] = RW'(nr);
            n_ovf0[l] = (RW'(nr) >> Q_W) >= RW'(i_den[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_rem0;
        r_den[0]  <= i_den;
        r_quo[0]  <= '0;
        r_ovf[0]  <= n_ovf0;
        r_side[0] <= i_side;
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        localparam int STG_BIT = Q_W - k;

        logic [LANES-1:0][RW-1:0]  n_rem;
        logic [LANES-1:0][Q_W-1:0] n_quo;

        always_comb begin
            logic [RW-1:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = RW'(r_den[k-1][l]) << STG_BIT;
                if (r_rem[k-1][l] >= trial) begin
                    n_rem[l] = r_rem[k-1][l] - trial;
                    n_quo[l] = r_quo[k-1][l] | (Q_W'(1) << STG_BIT);
                end else begin
                    n_rem[l] = r_rem[k-1][l];
                    n_quo[l] = r_quo[k-1][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_quo[k]  <= n_quo;
            r_ovf[k]  <= r_ovf[k-1];
            r_side[k] <= r_side[k-1];
        end

        // Remainder and divisor are dead after the last bit
        if (k < Q_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_rem;
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_vld  = r_vld[Q_W];
    assign o_quo  = r_quo[Q_W];
    assign o_ovf  = r_ovf[Q_W];
    assign o_side = r_side[Q_W];

endmodule

`default_nettype wire

// ===== dv/three_view_min_chi2_point_top_tb.sv =====
// Self-checking testbench for the three-view minimum chi-squared point fit.
`timescale 1ns / 1ps

module three_view_min_chi2_point_top_tb;
    import tvmc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int TRIG_REGS   = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = PIPE_LAT + 16;

    typedef struct {
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        chi_sq;
        logic               fit_error;
    } fit_t;

    typedef struct {
        t_coord u;
        t_coord v;
        t_coord w;
        t_sig   gu;
        t_sig   gv;
        t_sig   gw;
        logic   typed;
        fit_t   want;
    } hit_row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_start = 1'b0;
    t_coord       i_coord_u = '0;
    t_coord       i_coord_v = '0;
    t_coord       i_coord_w = '0;
    t_sig         i_weight_u = '0;
    t_sig         i_weight_v = '0;
    t_sig         i_weight_w = '0;
    logic         i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    t_trig        i_cfg_data = '0;
    logic         o_busy;
    logic         o_done;
    t_coord       o_pos_y;
    t_coord       o_pos_z;
    logic [CHI_W-1:0] o_chi_sq;
    logic         o_fit_error;
    logic         o_cfg_ready;

    three_view_min_chi2_point_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_coord_u   (i_coord_u),
        .i_coord_v   (i_coord_v),
        .i_coord_w   (i_coord_w),
        .i_weight_u  (i_weight_u),
        .i_weight_v  (i_weight_v),
        .i_weight_w  (i_weight_w),
        .o_done      (o_done),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_chi_sq    (o_chi_sq),
        .o_fit_error (o_fit_error),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_trig  trig_shadow [TRIG_REGS];
    fit_t   pending_fits [$];
    int     err_cnt = 0;
    int     fit_cnt = 0;
    int     err_fit_cnt = 0;
    int     sat_chi_cnt = 0;
    int     cycle_cnt = 0;
    bit     idle_on = 1'b1;

    // Round a right shift half away from zero
    function automatic longint rnd_q(input longint x, input int s);
        longint unsigned m;
        m = (x < 0) ? longint'(-x) : x;
        m = (m + (64'd1 << (s - 1))) >> s;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Divide rounding half away from zero, d positive
    function automatic longint div_q(input longint n, input longint d);
        longint unsigned m;
        m = (n < 0) ? longint'(-n) : n;
        m = (m + longint'(d) / 2) / longint'(d);
        return (n < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat_word(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // One plane's chi-squared contribution from a Q26 residual
    function automatic longint unsigned chi_part(input longint d26, input longint sg);
        longint unsigned m;
        longint unsigned dv;
        longint unsigned t;
        m  = (d26 < 0) ? longint'(-d26) : d26;
        dv = sg * 64;
        t  = (m + dv / 2) / dv;
        if (t >= (64'd1 << 24)) return 64'hFFFF_FFFF;
        return (t * t + (64'd1 << 15)) >> 16;
    endfunction

    function automatic longint trig_val(input int i);
        longint t;
        t = trig_shadow[i];
        if (t > 65536) t = 65536;
        if (t < -65536) t = -65536;
        return t;
    endfunction

    // Closed-form least-squares point and its chi-squared
    function automatic fit_t solve_point(input t_coord cu_in, input t_coord cv_in,
                                         input t_coord cw_in, input t_sig gu_in,
                                         input t_sig gv_in, input t_sig gw_in);
        fit_t   r;
        longint u, v, w, gu, gv, gw;
        longint su, cu, sv, cv, sp;
        longint su2, sv2, cvsv, cusu, cvsp, cusp, svsp, susp, a, a2;
        longint kyu, kyv, kyw, kzu, kzv, kzw, den, y, z;
        longint unsigned chi;
        u = cu_in; v = cv_in; w = cw_in;
        gu = gu_in; gv = gv_in; gw = gw_in;
        r = '{0, 0, 0, 1'b1};
        if (gu == 0 || gv == 0 || gw == 0) return r;
        su = trig_val(CFG_SIN_U);
        cu = trig_val(CFG_COS_U);
        sv = trig_val(CFG_SIN_V);
        cv = trig_val(CFG_COS_V);
        sp = trig_val(CFG_SIN_UPV);
        su2  = rnd_q(su * su, 16);
        sv2  = rnd_q(sv * sv, 16);
        cvsv = rnd_q(cv * sv, 16);
        cusu = rnd_q(cu * su, 16);
        cvsp = rnd_q(cv * sp, 16);
        cusp = rnd_q(cu * sp, 16);
        svsp = rnd_q(sv * sp, 16);
        susp = rnd_q(su * sp, 16);
        a    = rnd_q(cv * su + cu * sv, 16);
        a2   = rnd_q(a * a, 16);
        kyu = rnd_q(-(gv * su + gw * cvsp), 4);
        kyv = rnd_q(gu * sv + gw * cusp, 4);
        kyw = rnd_q(gv * cusu - gu * cvsv, 4);
        kzu = rnd_q(gw * svsp, 4);
        kzv = rnd_q(gw * susp, 4);
        kzw = rnd_q(gu * sv2 + gv * su2, 4);
        den = rnd_q(gv * su2 + gu * sv2 + gw * a2, 4);
        if (den <= 0) return r;
        y = sat_word(div_q(kyu * u + kyv * v + kyw * w, den));
        z = sat_word(div_q(kzu * u + kzv * v + kzw * w, den));
        chi = chi_part(u * 65536 - z * cu + y * su, gu);
        chi += chi_part(v * 65536 - z * cv - y * sv, gv);
        if (chi > 64'hFFFF_FFFF) chi = 64'hFFFF_FFFF;
        chi += chi_part((w - z) * 65536, gw);
        if (chi > 64'hFFFF_FFFF) chi = 64'hFFFF_FFFF;
        r.pos_y     = y[31:0];
        r.pos_z     = z[31:0];
        r.chi_sq    = chi[31:0];
        r.fit_error = 1'b0;
        return r;
    endfunction

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d fits pending", cycle_cnt,
                     pending_fits.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Compare each result word with the oldest pending fit
    always @(posedge i_clk) begin
        fit_t want;
        if (o_done === 1'b1) begin
            if (pending_fits.size() == 0) begin
                err_cnt <= err_cnt + 1;
                if (err_cnt < 10) $display("unexpected result word at cycle %0d", cycle_cnt);
            end else begin
                want = pending_fits.pop_front();
                fit_cnt <= fit_cnt + 1;
                if (want.fit_error) err_fit_cnt <= err_fit_cnt + 1;
                if (want.chi_sq == 32'hFFFF_FFFF) sat_chi_cnt <= sat_chi_cnt + 1;
                if (o_pos_y !== want.pos_y || o_pos_z !== want.pos_z ||
                    o_chi_sq !== want.chi_sq || o_fit_error !== want.fit_error) begin
                    err_cnt <= err_cnt + 1;
                    if (err_cnt < 10) begin
                        $display("mismatch at cycle %0d:", cycle_cnt);
                        $display("  pos_y  exp %0d got %0d", want.pos_y, o_pos_y);
                        $display("  pos_z  exp %0d got %0d", want.pos_z, o_pos_z);
                        $display("  chi_sq exp %0d got %0d", want.chi_sq, o_chi_sq);
                        $display("  err    exp %0b got %0b", want.fit_error, o_fit_error);
                    end
                end
            end
        end
    end

    // Present one hit, hold it until accepted, then idle at random
    task automatic send_hit(input hit_row_t h);
        i_coord_u  <= h.u;
        i_coord_v  <= h.v;
        i_coord_w  <= h.w;
        i_weight_u <= h.gu;
        i_weight_v <= h.gv;
        i_weight_w <= h.gw;
        i_start    <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        pending_fits.push_back(h.typed ? h.want
                               : solve_point(h.u, h.v, h.w, h.gu, h.gv, h.gw));
        while (idle_on && $urandom_range(99) < 36) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop start and hold until every pending fit has come back
    task automatic drain_fits();
        i_start <= 1'b0;
        while (pending_fits.size() != 0) @(posedge i_clk);
    endtask

    // Write one register word; valid stays up for back-to-back writes
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input t_trig data);
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < TRIG_REGS) trig_shadow[idx] = data;
    endtask

    task automatic set_trig(input t_trig su, input t_trig cu, input t_trig sv,
                            input t_trig cv, input t_trig sp);
        cfg_write(CFG_SIN_U, su);
        cfg_write(CFG_COS_U, cu);
        cfg_write(CFG_SIN_V, sv);
        cfg_write(CFG_COS_V, cv);
        cfg_write(CFG_SIN_UPV, sp);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_coord rand_coord();
        if ($urandom_range(3) == 0) return $urandom;
        return int'($urandom_range(2097152)) - 1048576;
    endfunction

    function automatic t_sig rand_sigma();
        int pick;
        pick = $urandom_range(39);
        if (pick == 0) return '0;
        if (pick < 11) return $urandom_range(65535);
        return $urandom_range(2048, 32);
    endfunction

    function automatic t_trig rand_trig();
        return int'($urandom_range(131072)) - 65536;
    endfunction

    task automatic random_hits(input int n);
        hit_row_t h;
        for (int k = 0; k < n; k++) begin
            h.u = rand_coord();
            h.v = rand_coord();
            h.w = rand_coord();
            h.gu = rand_sigma();
            h.gv = rand_sigma();
            h.gw = rand_sigma();
            h.typed = 1'b0;
            send_hit(h);
        end
    endtask

    // Directed hits under reset trig values
    hit_row_t dir_rows [] = '{
        '{0, 0, 0, 16'h0100, 16'h0100, 16'h0100, 1'b1, '{0, 0, 0, 1'b0}},
        '{1024, -2048, 512, 16'h0000, 16'h0100, 16'h0100, 1'b1, '{0, 0, 0, 1'b1}},
        '{32'h7FFF_FFFF, 32'h8000_0000, 5, 16'h0100, 16'h0000, 16'h0100, 1'b1,
          '{0, 0, 0, 1'b1}},
        '{32'h8000_0000, 32'h7FFF_FFFF, -5, 16'h0100, 16'h0100, 16'h0000, 1'b1,
          '{0, 0, 0, 1'b1}},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 16'h0000,
          1'b1, '{0, 0, 0, 1'b1}},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b0, '{0, 0, 0, 1'b0}},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0001, 16'h0001, 16'h0001,
          1'b0, '{0, 0, 0, 1'b0}},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0001, 16'hFFFF, 16'h0100,
          1'b0, '{0, 0, 0, 1'b0}},
        '{1, -1, 0, 16'h0100, 16'h0100, 16'h0100, 1'b0, '{0, 0, 0, 1'b0}},
        '{102400, 51200, -20480, 16'h0080, 16'h0200, 16'h0400, 1'b0, '{0, 0, 0, 1'b0}},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 16'hAAAA, 16'h5555, 16'hFFFF,
          1'b0, '{0, 0, 0, 1'b0}},
        '{-1024, 3072, 2048, 16'h0100, 16'h0100, 16'h0001, 1'b0, '{0, 0, 0, 1'b0}}
    };

    hit_row_t zero_den_row = '{4096, -4096, 1024, 16'h0100, 16'h0200, 16'h0300, 1'b1,
                               '{0, 0, 0, 1'b1}};

    initial begin
        trig_shadow = '{RST_SIN_U, RST_COS_U, RST_SIN_V, RST_COS_V, RST_SIN_UPV};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under reset values
        foreach (dir_rows[k]) send_hit(dir_rows[k]);
        random_hits(60);
        drain_fits();

        // Zero denominator: both sines cleared; spare index must be ignored
        cfg_write(CFG_IDX_SPARE, 18'sd12345);
        set_trig(0, 65536, 0, -65536, 40000);
        send_hit(zero_den_row);
        send_hit(zero_den_row);
        random_hits(10);
        drain_fits();

        // Extremes at +-1.0 with no idling
        idle_on = 1'b0;
        set_trig(65536, -65536, 65536, 65536, -65536);
        random_hits(90);
        drain_fits();
        idle_on = 1'b1;

        // Out-of-range words clamp to +-1.0
        set_trig(131071, -131072, -131072, 131071, 100000);
        random_hits(80);
        drain_fits();

        // Random angles
        for (int p = 0; p < 3; p++) begin
            set_trig(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_trig());
            random_hits(70);
            drain_fits();
        end

        // Let any stray result words surface
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d fits: %0d flagged, %0d with saturated chi-squared,",
                 fit_cnt, err_fit_cnt, sat_chi_cnt);
        $display("under reset, zero-sine, extreme, clamped and random plane angles");
        if (err_cnt == 0 && pending_fits.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tvmc_pkg.sv
rtl/core/tvmc_div.sv
rtl/core/three_view_min_chi2_point_top.sv
dv/three_view_min_chi2_point_top_tb.sv
